// ----- design/khid_pkg.sv -----
// Shared types and constants for the keyboard scan to HID report block.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package khid_pkg;

  localparam int LEVEL_W    = 5;
  localparam int MAP_W      = 50;
  localparam int ENTRY_W    = 10;
  localparam int CODE_W     = 8;
  localparam int SLOT_COUNT = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [MAP_W-1:0] BASE_MAP_RESET = 50'd562955326588160;
  localparam logic [MAP_W-1:0] FN_MAP_RESET   = 50'd562967142735879;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_MAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FN_MAP   = 2'd1;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_MOD   = 2'd1,
    KIND_LAYER = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // running keyboard state that the key unit updates
  typedef struct packed {
    logic                                layer;
    logic [7:0]                          mods;
    logic [SLOT_COUNT-1:0][CODE_W-1:0]   slots;
  } khid_state_t;

endpackage

`default_nettype wire

// ----- design/khid_ifs.sv -----
// Valid/ready channel interfaces: scan input, report output, config writes.
// Depends on khid_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface khid_scan_if;
  logic                         valid;
  logic                         ready;
  logic [khid_pkg::LEVEL_W-1:0] key_levels;
  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

interface khid_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_byte;
  logic [7:0] slot_one;
  logic [7:0] slot_two;
  logic [7:0] slot_three;
  logic [7:0] slot_four;
  logic [7:0] slot_five;
  logic [7:0] slot_six;
  modport source (output valid, output modifier_byte, output slot_one, output slot_two,
                  output slot_three, output slot_four, output slot_five,
                  output slot_six, input ready);
  modport sink   (input valid, input modifier_byte, input slot_one, input slot_two,
                  input slot_three, input slot_four, input slot_five,
                  input slot_six, output ready);
endinterface

interface khid_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [khid_pkg::CFG_IDX_W-1:0] index;
  logic [khid_pkg::MAP_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/khid_key_unit.sv -----
// Shared key action unit: applies one key press or release to the state.
// Depends on khid_pkg (kind_t, khid_state_t).
`timescale 1ns / 1ps
`default_nettype none

module khid_key_unit (
  input  logic [khid_pkg::ENTRY_W-1:0] entry,
  input  logic                         press,
  input  khid_pkg::khid_state_t        cur,
  output khid_pkg::khid_state_t        nxt
);

  khid_pkg::kind_t            kind;
  logic [khid_pkg::CODE_W-1:0] code;

  assign kind = khid_pkg::kind_t'(entry[9:8]);
  assign code = entry[7:0];

  always_comb begin
    logic taken;
    logic seen;
    nxt   = cur;
    taken = 1'b0;
    seen  = 1'b0;
    unique case (kind)
      khid_pkg::KIND_LAYER: begin
        nxt.layer = press;
      end
      khid_pkg::KIND_MOD: begin
        // modifier index of 8 or more has no bit
        if (code[7:3] == 5'd0) begin
          nxt.mods[code[2:0]] = press;
        end
      end
      khid_pkg::KIND_KEY: begin
        if (press) begin
          // first empty slot with no earlier copy of the code
          for (int k = 0; k < khid_pkg::SLOT_COUNT; k++) begin
            if (!taken && !seen && cur.slots[k] == '0) begin
              nxt.slots[k] = code;
              taken        = 1'b1;
            end
            seen = seen | (cur.slots[k] == code);
          end
        end else begin
          for (int k = 0; k < khid_pkg::SLOT_COUNT; k++) begin
            if (cur.slots[k] == code) begin
              nxt.slots[k] = '0;
            end
          end
        end
      end
      khid_pkg::KIND_NONE: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/keyboard_scan_to_hid_report.sv -----
// Top level: scan sequencer, keymap registers and report output register.
// Depends on khid_pkg, khid_ifs (channel interfaces) and khid_key_unit.
//
//  channel  dir  payload                                   request taken when
//  scan     in   key_levels[4:0]                           valid && ready
//  report   out  modifier_byte, slot_one .. slot_six       valid && ready
//  cfg      in   index[1:0], data[49:0]                    valid && ready (always ready)
//
// A scan equal to the previous one is accepted and gives no report.
// A changed scan is accepted, then its KN = min(KEYS, 5) keys go one at a time
// through the shared key unit, and then the report is loaded.
// The report load waits while the output register still holds an untaken report.
// rst (synchronous) restores the reset keymaps and clears all key state.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_scan_to_hid_report #(
  parameter int KEYS = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  khid_scan_if.sink          scan,
  khid_report_if.source      report,
  khid_cfg_if.sink           cfg
);

  localparam int KN    = (KEYS < khid_pkg::LEVEL_W) ? KEYS : khid_pkg::LEVEL_W;
  localparam int IDX_W = (KN > 1) ? $clog2(KN) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KN - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } seq_state_t;

  seq_state_t                   state;
  logic [khid_pkg::MAP_W-1:0]   base_map;
  logic [khid_pkg::MAP_W-1:0]   fn_map;
  logic [khid_pkg::LEVEL_W-1:0] prev_levels;
  logic [khid_pkg::LEVEL_W-1:0] levels;
  logic [KN-1:0]                press_layer;
  logic [IDX_W-1:0]             idx;
  khid_pkg::khid_state_t        st;
  khid_pkg::khid_state_t        st_next;

  logic                                              out_valid;
  logic [7:0]                                        out_mods;
  logic [khid_pkg::SLOT_COUNT-1:0][khid_pkg::CODE_W-1:0] out_slots;

  logic [KN-1:0]               key_now;
  logic [KN-1:0]               key_chg;
  logic                        press;
  logic                        entry_layer;
  logic [khid_pkg::MAP_W-1:0]  map_sel;
  logic [khid_pkg::ENTRY_W-1:0] entry;
  logic                        scan_req;
  logic                        emit_ok;

  assign scan.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign scan_req   = scan.valid && scan.ready;
  assign emit_ok    = !out_valid || report.ready;

  assign key_now     = levels[KN-1:0];
  assign key_chg     = levels[KN-1:0] ^ prev_levels[KN-1:0];
  assign press       = !key_now[idx];
  // release looks up the layer that was active at press
  assign entry_layer = press ? st.layer : press_layer[idx];
  assign map_sel     = entry_layer ? fn_map : base_map;

  always_comb begin
    entry = '0;
    for (int k = 0; k < KN; k++) begin
      if (idx == IDX_W'(k)) begin
        entry = map_sel[khid_pkg::ENTRY_W*k +: khid_pkg::ENTRY_W];
      end
    end
  end

  khid_key_unit u_key (
    .entry (entry),
    .press (press),
    .cur   (st),
    .nxt   (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      base_map    <= khid_pkg::BASE_MAP_RESET;
      fn_map      <= khid_pkg::FN_MAP_RESET;
      prev_levels <= '1;
      press_layer <= '0;
      st          <= '0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == khid_pkg::REG_BASE_MAP) begin
          base_map <= cfg.data;
        end else if (cfg.index == khid_pkg::REG_FN_MAP) begin
          fn_map <= cfg.data;
        end
      end

      // a report load in the same cycle refills the register instead
      if (out_valid && report.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (scan_req && scan.key_levels != prev_levels) begin
            levels <= scan.key_levels;
            idx    <= '0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (key_chg[idx]) begin
            st <= st_next;
            if (press) begin
              press_layer[idx] <= st.layer;
            end
          end
          if (idx == LAST_IDX) begin
            state <= ST_EMIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid   <= 1'b1;
            out_mods    <= st.mods;
            out_slots   <= st.slots;
            prev_levels <= levels;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign report.valid         = out_valid;
  assign report.modifier_byte = out_mods;
  assign report.slot_one      = out_slots[0];
  assign report.slot_two      = out_slots[1];
  assign report.slot_three    = out_slots[2];
  assign report.slot_four     = out_slots[3];
  assign report.slot_five     = out_slots[4];
  assign report.slot_six      = out_slots[5];

endmodule

`default_nettype wire
